[hdl/assert_macros.svh]
// Assertion macros used by the sfpr_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[hdl/sfpr_pkg.sv]
package sfpr_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 32;

    localparam logic [7:0] SYNC_FIRST  = 8'h7A;
    localparam logic [7:0] SYNC_SECOND = 8'h1D;

    localparam logic ACTION_BYTE    = 1'b0;
    localparam logic ACTION_SILENCE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  command;
        logic [7:0]  message_id;
        logic [5:0]  payload_length;
        logic [4:0]  byte_index;
        logic [7:0]  payload_byte;
        logic        last;
        logic [15:0] error_count;
    } result_t;

    typedef struct packed {
        logic load_cmd;
        logic load_id;
        logic load_len;
        logic write_byte;
        logic count_err;
        logic start_drain;
        logic read_en;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic sync_first;
        logic sync_second;
        logic len_zero;
        logic len_over;
        logic fill_done;
        logic id_dup;
        logic drain_last;
    } dp_status_t;

endpackage

[hdl/sfpr_ram.sv]
module sfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/sfpr_ctrl.sv]
module sfpr_ctrl
    import sfpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       action,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        HUNT1,
        HUNT2,
        CMD,
        ID,
        LEN,
        DATA,
        READ,
        EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   valid_reg;
    logic   accept;

    assign accept       = item_valid && !stall_reg;
    assign item_stall   = stall_reg;
    assign result_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (accept && action == ACTION_SILENCE)
        begin
            if (state_reg != HUNT1)
            begin
                cmd.count_err = 1'b1;
                state_next    = HUNT1;
            end
        end
        else
        begin
            case (state_reg)
                HUNT1:
                begin
                    if (accept)
                    begin
                        if (status.sync_first)
                            state_next = HUNT2;
                        else
                            cmd.count_err = 1'b1;
                    end
                end
                HUNT2:
                begin
                    if (accept)
                    begin
                        if (status.sync_second)
                        begin
                            state_next = CMD;
                        end
                        else
                        begin
                            cmd.count_err = 1'b1;
                            state_next    = HUNT1;
                        end
                    end
                end
                CMD:
                begin
                    if (accept)
                    begin
                        cmd.load_cmd = 1'b1;
                        state_next   = ID;
                    end
                end
                ID:
                begin
                    if (accept)
                    begin
                        cmd.load_id = 1'b1;
                        state_next  = LEN;
                    end
                end
                LEN:
                begin
                    if (accept)
                    begin
                        cmd.load_len  = 1'b1;
                        cmd.count_err = status.len_over;
                        if (!status.len_zero)
                        begin
                            state_next = DATA;
                        end
                        else if (status.id_dup)
                        begin
                            state_next = HUNT1;
                        end
                        else
                        begin
                            cmd.start_drain = 1'b1;
                            state_next      = READ;
                        end
                    end
                end
                DATA:
                begin
                    if (accept)
                    begin
                        cmd.write_byte = 1'b1;
                        if (status.fill_done)
                        begin
                            if (status.id_dup)
                            begin
                                state_next = HUNT1;
                            end
                            else
                            begin
                                cmd.start_drain = 1'b1;
                                state_next      = READ;
                            end
                        end
                    end
                end
                READ:
                begin
                    cmd.read_en = 1'b1;
                    state_next  = EMIT;
                end
                EMIT:
                begin
                    if (!result_stall)
                    begin
                        if (status.drain_last)
                        begin
                            state_next = HUNT1;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = READ;
                        end
                    end
                end
                default:
                begin
                    state_next = HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HUNT1;
            stall_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next == READ) || (state_next == EMIT);
            valid_reg <= (state_next == EMIT);
        end
    end

endmodule

[hdl/sfpr_dp.sv]
module sfpr_dp
    import sfpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic [7:0] rx_byte,
    output dp_status_t status,
    output result_t    result
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]    command_reg;
    logic [7:0]    command_next;
    logic [7:0]    id_reg;
    logic [7:0]    id_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] fill_reg;
    logic [LW-1:0] fill_next;
    logic [7:0]    last_id_reg;
    logic [7:0]    last_id_next;
    logic [15:0]   err_reg;
    logic [15:0]   err_next;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] k_next;
    logic [LW-1:0] fill_inc;
    logic [LW-1:0] k_inc;
    logic [LW-1:0] count;
    logic [7:0]    rdata;

    assign fill_inc = fill_reg + LW'(1);
    assign k_inc    = LW'(k_reg) + LW'(1);
    assign count    = (len_reg == '0) ? LW'(1) : len_reg;

    assign status.sync_first  = (rx_byte == SYNC_FIRST);
    assign status.sync_second = (rx_byte == SYNC_SECOND);
    assign status.len_zero    = (rx_byte == 8'h00);
    assign status.len_over    = (rx_byte > 8'(MAX_PAYLOAD));
    assign status.fill_done   = (fill_inc >= len_reg);
    assign status.id_dup      = (id_reg == last_id_reg);
    assign status.drain_last  = (k_inc == count);

    always_comb
    begin
        command_next = cmd.load_cmd ? rx_byte : command_reg;
        id_next      = cmd.load_id ? rx_byte : id_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        if (cmd.load_len)
        begin
            len_next  = status.len_over ? LW'(MAX_PAYLOAD) : LW'(rx_byte);
            fill_next = '0;
        end
        else if (cmd.write_byte)
        begin
            fill_next = fill_inc;
        end
        last_id_next = cmd.start_drain ? id_reg : last_id_reg;
        err_next     = (cmd.count_err && err_reg != 16'hFFFF) ? err_reg + 16'd1 : err_reg;
        k_next       = k_reg;
        if (cmd.start_drain)
            k_next = '0;
        else if (cmd.advance)
            k_next = k_inc[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg <= '0;
            id_reg      <= '0;
            len_reg     <= '0;
            fill_reg    <= '0;
            last_id_reg <= '0;
            err_reg     <= '0;
            k_reg       <= '0;
        end
        else
        begin
            command_reg <= command_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            fill_reg    <= fill_next;
            last_id_reg <= last_id_next;
            err_reg     <= err_next;
            k_reg       <= k_next;
        end
    end

    sfpr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (cmd.write_byte),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.read_en),
        .raddr (k_reg),
        .rdata (rdata)
    );

    assign result.command        = command_reg;
    assign result.message_id     = id_reg;
    assign result.payload_length = 6'(len_reg);
    assign result.byte_index     = 5'(k_reg);
    assign result.payload_byte   = (len_reg == '0) ? 8'h00 : rdata;
    assign result.last           = status.drain_last;
    assign result.error_count    = err_reg;

endmodule

[hdl/sync_framed_packet_receiver_core.sv]
// Deframes a serial byte stream of the form 0x7A, 0x1D, command, message id,
// length, payload, and delivers each new frame (id differing from the last
// delivered id, which starts at 0) as one result word per payload byte, or a
// single word for an empty payload, with last set on the final word. Lengths
// above MAX_PAYLOAD are clamped. Bad sync bytes, clamped lengths and silence
// inside a frame count framing errors, saturating at 65535. Received bytes
// and silence events are taken while item_stall is low. Delivery of a frame
// holds item_stall high; each result word takes a payload store read, then
// presentation, and result_stall can hold a word. No clearing pass after
// reset.
module sync_framed_packet_receiver_core
    import sfpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sfpr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .action       (item.action),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    sfpr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rx_byte (item.rx_byte),
        .status  (status),
        .result  (result)
    );

endmodule

[hdl/sfpr_chk.sv]
`include "assert_macros.svh"

module sfpr_chk
    import sfpr_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    `ASSERT_CLK(a_result_hold, clk, rst_n,
        result_valid && result_stall |=> result_valid && $stable(result),
        "stalled result word changed")

    `ASSERT_NEVER(a_no_take_while_delivering, clk, rst_n,
        result_valid && !item_stall,
        "input open while a result word is shown")

    `ASSERT_CLK(a_read_gap, clk, rst_n,
        result_valid && !result_stall && !result.last |=> !result_valid,
        "result word without store read cycle")

    `ASSERT_CLK(a_frame_continues, clk, rst_n,
        result_valid && !result_stall && !result.last |-> ##2 result_valid
            && result.message_id == $past(result.message_id, 2)
            && result.error_count == $past(result.error_count, 2),
        "frame delivery broke off")

endmodule

bind sync_framed_packet_receiver_core sfpr_chk u_chk (.*);
